@@ design/hedge_pkg.sv @@
// hedge_pkg: shared constants and codes of the homogeneity edge operator
// no dependencies; used by homogeneity_edge_operator, edge_map_checker and the testbench
`timescale 1ns / 1ps
`default_nettype none

package hedge_pkg;

  // parameter defaults
  localparam int DEF_WINDOW    = 3;
  localparam int DEF_MAX_WIDTH = 2048;

  // field and register widths
  localparam int PIX_W     = 8;
  localparam int ROW_W     = 12;
  localparam int OUT_COL_W = 11;
  localparam int FW_W      = 12;
  localparam int FH_W      = 13;

  localparam int MAX_HEIGHT = 4096;

  localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = FW_W'(640);
  localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = FH_W'(480);

  // configuration port
  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  typedef enum logic {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

endpackage

`default_nettype wire

@@ design/hedge_ram.sv @@
// hedge_ram: generic single write port, single read port RAM
// registered read with read enable, read-old on same-address write; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module hedge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ design/homogeneity_edge_operator.sv @@
// homogeneity_edge_operator: streaming homogeneity edge detector, raster in, raster out
// depends on hedge_pkg and hedge_ram
//
//   channel  | handshake             | word
//   ---------+-----------------------+--------------------------------------------
//   config   | psel/penable/pwrite   | paddr 0 frame_width, paddr 4 frame_height
//   input    | in_valid / in_ready   | in_command, in_pixel
//   output   | out_valid / out_ready | out_edge_value, out_row, out_col,
//            |                       | out_last_of_frame
//
// one word per cycle in and out while neither side stalls; a result is registered in the read
// stage (line store read), then in the output register (after the window max)
// the line store is WINDOW x WINDOW banks, so all window pixels are read in the same cycle
// reset clears positions, pending count and valids; the line store is not cleared
// in_ready drops only while both the read stage and the output register are full

`timescale 1ns / 1ps
`default_nettype none

module homogeneity_edge_operator #(
  parameter int WINDOW    = hedge_pkg::DEF_WINDOW,
  parameter int MAX_WIDTH = hedge_pkg::DEF_MAX_WIDTH
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [hedge_pkg::APB_AW-1:0]    paddr,
  input  wire logic [hedge_pkg::APB_DW-1:0]    pwdata,
  output logic      [hedge_pkg::APB_DW-1:0]    prdata,
  output logic                                 pready,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_command,
  input  wire logic [hedge_pkg::PIX_W-1:0]     in_pixel,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic      [hedge_pkg::PIX_W-1:0]     out_edge_value,
  output logic      [hedge_pkg::ROW_W-1:0]     out_row,
  output logic      [hedge_pkg::OUT_COL_W-1:0] out_col,
  output logic                                 out_last_of_frame
);

  import hedge_pkg::*;

  localparam int HALF   = WINDOW / 2;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WE_W   = COL_W + 1;
  localparam int MW     = $clog2(WINDOW);
  localparam int BANK_D = (MAX_WIDTH + WINDOW - 1) / WINDOW;
  localparam int BA_W   = $clog2(BANK_D);
  localparam int PEND_W = $clog2(HALF * MAX_WIDTH + HALF + 2);
  localparam int NB     = WINDOW * WINDOW;

  // ---------------- configuration registers
  logic [FW_W-1:0] frame_width_r;
  logic [FH_W-1:0] frame_height_r;
  logic            cfg_wr;
  reg_idx_t        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[APB_AW-1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_FRAME_WIDTH:  frame_width_r  <= pwdata[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_r <= pwdata[FH_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DW'(frame_width_r);
      REG_FRAME_HEIGHT: prdata = APB_DW'(frame_height_r);
    endcase
  end

  // clamped frame size
  logic [WE_W-1:0]   w_eff;
  logic [FH_W-1:0]   h_eff;
  logic [PEND_W-1:0] delay;

  always_comb begin
    if (frame_width_r == '0) begin
      w_eff = WE_W'(1);
    end else if (frame_width_r > MAX_WIDTH) begin
      w_eff = WE_W'(MAX_WIDTH);
    end else begin
      w_eff = WE_W'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h_eff = FH_W'(1);
    end else if (frame_height_r > FH_W'(MAX_HEIGHT)) begin
      h_eff = FH_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height_r;
    end
  end

  assign delay = PEND_W'(w_eff) * PEND_W'(HALF) + PEND_W'(HALF);

  // ---------------- position state
  logic [ROW_W-1:0]  in_row_r,  in_row_nxt,  em_row_r,  em_row_nxt;
  logic [MW-1:0]     in_rm_r,   in_rm_nxt,   em_rm_r,   em_rm_nxt;
  logic [COL_W-1:0]  in_col_r,  in_col_nxt,  em_col_r,  em_col_nxt;
  logic [BA_W-1:0]   in_cq_r,   in_cq_nxt,   em_cq_r,   em_cq_nxt;
  logic [MW-1:0]     in_cm_r,   in_cm_nxt,   em_cm_r,   em_cm_nxt;
  logic [PEND_W-1:0] pending_r, pending_nxt;
  logic [PEND_W:0]   pend_inc;

  logic accept, is_pixel, emit, wr_en, rd_en;
  logic s1_valid_r, s1_valid_nxt, out_valid_r, out_valid_nxt, out_adv;

  assign out_adv  = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_adv;
  assign accept   = in_valid && in_ready;
  assign is_pixel = cmd_t'(in_command) == CMD_PIXEL;
  assign pend_inc = {1'b0, pending_r} + 1'b1;
  assign emit     = is_pixel ? (pend_inc > {1'b0, delay}) : (pending_r != '0);
  assign wr_en    = accept && is_pixel && ({1'b0, in_col_r} < w_eff);
  assign rd_en    = accept && emit;

  // raster advance of the input position, column kept also as bank and bank address
  always_comb begin
    in_row_nxt = in_row_r;
    in_rm_nxt  = in_rm_r;
    in_col_nxt = in_col_r;
    in_cq_nxt  = in_cq_r;
    in_cm_nxt  = in_cm_r;
    if (accept && is_pixel) begin
      if ({1'b0, in_col_r} + 1'b1 >= w_eff) begin
        in_col_nxt = '0;
        in_cq_nxt  = '0;
        in_cm_nxt  = '0;
        if ({1'b0, in_row_r} + 1'b1 >= h_eff) begin
          in_row_nxt = '0;
          in_rm_nxt  = '0;
        end else begin
          in_row_nxt = in_row_r + 1'b1;
          in_rm_nxt  = (in_rm_r == MW'(WINDOW - 1)) ? '0 : in_rm_r + 1'b1;
        end
      end else begin
        in_col_nxt = in_col_r + 1'b1;
        if (in_cm_r == MW'(WINDOW - 1)) begin
          in_cm_nxt = '0;
          in_cq_nxt = in_cq_r + 1'b1;
        end else begin
          in_cm_nxt = in_cm_r + 1'b1;
        end
      end
    end
  end

  // raster advance of the emit position
  always_comb begin
    em_row_nxt = em_row_r;
    em_rm_nxt  = em_rm_r;
    em_col_nxt = em_col_r;
    em_cq_nxt  = em_cq_r;
    em_cm_nxt  = em_cm_r;
    if (rd_en) begin
      if ({1'b0, em_col_r} + 1'b1 >= w_eff) begin
        em_col_nxt = '0;
        em_cq_nxt  = '0;
        em_cm_nxt  = '0;
        if ({1'b0, em_row_r} + 1'b1 >= h_eff) begin
          em_row_nxt = '0;
          em_rm_nxt  = '0;
        end else begin
          em_row_nxt = em_row_r + 1'b1;
          em_rm_nxt  = (em_rm_r == MW'(WINDOW - 1)) ? '0 : em_rm_r + 1'b1;
        end
      end else begin
        em_col_nxt = em_col_r + 1'b1;
        if (em_cm_r == MW'(WINDOW - 1)) begin
          em_cm_nxt = '0;
          em_cq_nxt = em_cq_r + 1'b1;
        end else begin
          em_cm_nxt = em_cm_r + 1'b1;
        end
      end
    end
  end

  always_comb begin
    pending_nxt = pending_r;
    if (accept) begin
      if (is_pixel) begin
        // a pixel that also emits leaves the count unchanged
        pending_nxt = emit ? pending_r : pend_inc[PEND_W-1:0];
      end else if (emit) begin
        pending_nxt = pending_r - 1'b1;
      end
    end
  end

  assign s1_valid_nxt  = accept ? emit : (s1_valid_r && !out_adv);
  assign out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_row_r    <= '0;
      in_rm_r     <= '0;
      in_col_r    <= '0;
      in_cq_r     <= '0;
      in_cm_r     <= '0;
      em_row_r    <= '0;
      em_rm_r     <= '0;
      em_col_r    <= '0;
      em_cq_r     <= '0;
      em_cm_r     <= '0;
      pending_r   <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_row_r    <= in_row_nxt;
      in_rm_r     <= in_rm_nxt;
      in_col_r    <= in_col_nxt;
      in_cq_r     <= in_cq_nxt;
      in_cm_r     <= in_cm_nxt;
      em_row_r    <= em_row_nxt;
      em_rm_r     <= em_rm_nxt;
      em_col_r    <= em_col_nxt;
      em_cq_r     <= em_cq_nxt;
      em_cm_r     <= em_cm_nxt;
      pending_r   <= pending_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------- line store, one bank per (row slot, column mod WINDOW)
  logic [BA_W-1:0]  rd_addr [WINDOW];
  logic [PIX_W-1:0] rd_data [WINDOW][WINDOW];
  logic [NB-1:0]    byp_nxt;

  for (genvar b = 0; b < WINDOW; b++) begin : g_addr
    // each bank holds exactly one window column; pick its neighbor block when it wraps
    assign rd_addr[b] = (b > int'(em_cm_r) + HALF) ? em_cq_r - 1'b1 :
                        (b + HALF < int'(em_cm_r)) ? em_cq_r + 1'b1 : em_cq_r;
  end

  for (genvar s = 0; s < WINDOW; s++) begin : g_slot
    for (genvar b = 0; b < WINDOW; b++) begin : g_bank
      logic we_sb;

      assign we_sb = wr_en && (in_rm_r == MW'(s)) && (in_cm_r == MW'(b));
      // the pixel written in this cycle is also read in this cycle
      assign byp_nxt[s * WINDOW + b] = we_sb && (rd_addr[b] == in_cq_r);

      hedge_ram #(
        .WIDTH (PIX_W),
        .DEPTH (BANK_D)
      ) u_ram (
        .clk   (clk),
        .we    (we_sb),
        .waddr (in_cq_r),
        .wdata (in_pixel),
        .re    (rd_en),
        .raddr (rd_addr[b]),
        .rdata (rd_data[s][b])
      );
    end
  end

  // ---------------- read stage
  logic [NB-1:0]        byp_r;
  logic [PIX_W-1:0]     wpix_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic [OUT_COL_W-1:0] s1_col_r;
  logic                 s1_last_r, s1_int_r;
  logic [MW-1:0]        s1_cs_r, s1_cb_r;
  logic                 em_int, em_last;

  assign em_int = (em_row_r >= ROW_W'(HALF)) &&
                  ({1'b0, em_row_r} + FH_W'(HALF) < h_eff) &&
                  (em_col_r >= COL_W'(HALF)) &&
                  ({1'b0, em_col_r} + WE_W'(HALF) < w_eff);
  assign em_last = ({1'b0, em_row_r} + 1'b1 == h_eff) &&
                   ({1'b0, em_col_r} + 1'b1 == w_eff);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_r     <= byp_nxt;
      wpix_r    <= in_pixel;
      s1_row_r  <= em_row_r;
      s1_col_r  <= OUT_COL_W'(em_col_r);
      s1_last_r <= em_last;
      s1_int_r  <= em_int;
      s1_cs_r   <= em_rm_r;
      s1_cb_r   <= em_cm_r;
    end
  end

  // window max; the bank order does not matter, only the centre bank is picked out
  logic [PIX_W-1:0] win_val [WINDOW][WINDOW];
  logic [PIX_W-1:0] diff    [WINDOW][WINDOW];
  logic [PIX_W-1:0] row_max [WINDOW];
  logic [PIX_W-1:0] centre, edge_max;

  for (genvar s = 0; s < WINDOW; s++) begin : g_val
    for (genvar b = 0; b < WINDOW; b++) begin : g_vb
      assign win_val[s][b] = byp_r[s * WINDOW + b] ? wpix_r : rd_data[s][b];
      assign diff[s][b]    = (win_val[s][b] > centre) ? win_val[s][b] - centre
                                                      : centre - win_val[s][b];
    end
  end

  always_comb begin
    centre = '0;
    for (int s = 0; s < WINDOW; s++) begin
      for (int b = 0; b < WINDOW; b++) begin
        if ((s1_cs_r == MW'(s)) && (s1_cb_r == MW'(b))) begin
          centre = win_val[s][b];
        end
      end
    end
  end

  always_comb begin
    for (int s = 0; s < WINDOW; s++) begin
      row_max[s] = '0;
      for (int b = 0; b < WINDOW; b++) begin
        if (diff[s][b] > row_max[s]) begin
          row_max[s] = diff[s][b];
        end
      end
    end
  end

  always_comb begin
    edge_max = '0;
    for (int s = 0; s < WINDOW; s++) begin
      if (row_max[s] > edge_max) begin
        edge_max = row_max[s];
      end
    end
  end

  // ---------------- output register
  logic [PIX_W-1:0]     out_edge_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [OUT_COL_W-1:0] out_col_r;
  logic                 out_last_r;

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      out_edge_r <= s1_int_r ? edge_max : '0;
      out_row_r  <= s1_row_r;
      out_col_r  <= s1_col_r;
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_edge_value    = out_edge_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_last_of_frame = out_last_r;

endmodule

`default_nettype wire

@@ tb/sv/edge_map_checker.sv @@
// edge_map_checker: watches the register port and both word channels of the edge operator,
// predicts each result word from its own line store and compares in order
// depends on hedge_pkg
`timescale 1ns / 1ps

module edge_map_checker
  import hedge_pkg::*;
#(
  parameter int WINDOW    = DEF_WINDOW,
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [APB_AW-1:0]    paddr,
  input  logic [APB_DW-1:0]    pwdata,
  input  logic                 pready,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic                 in_command,
  input  logic [PIX_W-1:0]     in_pixel,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [PIX_W-1:0]     out_edge_value,
  input  logic [ROW_W-1:0]     out_row,
  input  logic [OUT_COL_W-1:0] out_col,
  input  logic                 out_last_of_frame,
  output int unsigned          mismatches,
  output int unsigned          outstanding,
  output int unsigned          compared
);

  localparam int HALF = WINDOW / 2;

  typedef struct packed {
    logic [PIX_W-1:0]     edge_value;
    logic [ROW_W-1:0]     row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } edge_word_t;

  logic [FW_W-1:0]   width_reg;
  logic [FH_W-1:0]   height_reg;
  bit   [PIX_W-1:0]  lines [WINDOW][MAX_WIDTH];
  int unsigned       wr_row, wr_col, rd_row, rd_col, backlog;
  int unsigned       n_err, n_cmp, w, h;
  logic [APB_AW-1:0] reg_sel;
  edge_word_t        edge_q[$];
  edge_word_t        want;
  edge_word_t        fresh;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    compared    = 0;
    n_err       = 0;
    n_cmp       = 0;
  end

  function automatic int unsigned width_eff();
    int unsigned v;
    v = width_reg;
    if (v == 0) v = 1;
    if (v > MAX_WIDTH) v = MAX_WIDTH;
    return v;
  endfunction

  function automatic int unsigned height_eff();
    int unsigned v;
    v = height_reg;
    if (v == 0) v = 1;
    if (v > MAX_HEIGHT) v = MAX_HEIGHT;
    return v;
  endfunction

  function automatic void step_pos(inout int unsigned r, inout int unsigned c,
                                   input int unsigned fw, input int unsigned fh);
    if (c + 1 >= fw) begin
      c = 0;
      r = (r + 1 >= fh) ? 0 : r + 1;
    end else begin
      c = c + 1;
    end
  endfunction

  function automatic int unsigned line_pixel(int unsigned r, int unsigned c);
    if (c >= MAX_WIDTH) return 0;
    return lines[r % WINDOW][c];
  endfunction

  // max centre-to-neighbour difference at the emit position, then advance it
  function automatic edge_word_t next_edge_word(int unsigned fw, int unsigned fh);
    edge_word_t  ew;
    int unsigned centre, p, d, best, dy, dx;
    best = 0;
    if (rd_row >= HALF && rd_row + HALF < fh && rd_col >= HALF && rd_col + HALF < fw) begin
      centre = line_pixel(rd_row, rd_col);
      for (dy = 0; dy < WINDOW; dy++) begin
        for (dx = 0; dx < WINDOW; dx++) begin
          p = line_pixel(rd_row - HALF + dy, rd_col - HALF + dx);
          d = (p > centre) ? p - centre : centre - p;
          if (d > best) best = d;
        end
      end
    end
    ew.edge_value = best[PIX_W-1:0];
    ew.row        = rd_row[ROW_W-1:0];
    ew.col        = rd_col[OUT_COL_W-1:0];
    ew.last       = (rd_row + 1 == fh) && (rd_col + 1 == fw);
    step_pos(rd_row, rd_col, fw, fh);
    return ew;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      width_reg  = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      wr_row     = 0;
      wr_col     = 0;
      rd_row     = 0;
      rd_col     = 0;
      backlog    = 0;
      edge_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        n_cmp++;
        if (edge_q.size() == 0) begin
          $error("result word with nothing expected: row %0d col %0d edge %0d",
                 out_row, out_col, out_edge_value);
          n_err++;
        end else begin
          want = edge_q.pop_front();
          check_field("edge_value", want.edge_value, out_edge_value);
          check_field("out_row", want.row, out_row);
          check_field("out_col", want.col, out_col);
          check_field("last_of_frame", want.last, out_last_of_frame);
        end
      end

      if (psel && penable && pwrite && pready) begin
        reg_sel = paddr >> 2;
        if (reg_sel == REG_FRAME_WIDTH) width_reg = pwdata[FW_W-1:0];
        else if (reg_sel == REG_FRAME_HEIGHT) height_reg = pwdata[FH_W-1:0];
      end

      if (in_valid && in_ready) begin
        w = width_eff();
        h = height_eff();
        if (in_command == CMD_FLUSH) begin
          if (backlog != 0) begin
            fresh  = next_edge_word(w, h);
            edge_q = {edge_q, fresh};
            backlog--;
          end
        end else begin
          // columns beyond a shrunken width are not stored
          if (wr_col < w) lines[wr_row % WINDOW][wr_col] = in_pixel;
          step_pos(wr_row, wr_col, w, h);
          backlog++;
          if (backlog > HALF * w + HALF) begin
            fresh  = next_edge_word(w, h);
            edge_q = {edge_q, fresh};
            backlog--;
          end
        end
      end
    end
    mismatches  <= n_err;
    outstanding <= edge_q.size();
    compared    <= n_cmp;
  end

endmodule

@@ tb/sv/tb_homogeneity_edge_operator.sv @@
// tb_homogeneity_edge_operator: drives frames, flushes and register writes into the
// edge operator with random idling on both sides; edge_map_checker does the checking
// depends on hedge_pkg, homogeneity_edge_operator and edge_map_checker
`timescale 1ns / 1ps

module tb_homogeneity_edge_operator;
  import hedge_pkg::*;

  localparam int WINDOW       = DEF_WINDOW;
  localparam int MAX_WIDTH    = DEF_MAX_WIDTH;
  localparam int HALF         = WINDOW / 2;
  localparam int SETTLE       = 8;
  localparam int RANDOM_WORDS = 1650;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [APB_AW-1:0]    paddr = '0;
  logic [APB_DW-1:0]    pwdata = '0;
  logic [APB_DW-1:0]    prdata;
  logic                 pready;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_command = CMD_PIXEL;
  logic [PIX_W-1:0]     in_pixel = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  logic [PIX_W-1:0]     out_edge_value;
  logic [ROW_W-1:0]     out_row;
  logic [OUT_COL_W-1:0] out_col;
  logic                 out_last_of_frame;

  int unsigned mismatches, outstanding, compared;
  int unsigned cur_w = RST_FRAME_WIDTH;
  int unsigned cur_h = RST_FRAME_HEIGHT;
  int unsigned held = 0;
  int unsigned n_words = 0, n_flush = 0, n_cfg = 0;
  bit          gaps_on = 1'b0;

  homogeneity_edge_operator #(
    .WINDOW   (WINDOW),
    .MAX_WIDTH(MAX_WIDTH)
  ) i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_edge_value   (out_edge_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last_of_frame(out_last_of_frame)
  );

  edge_map_checker #(
    .WINDOW   (WINDOW),
    .MAX_WIDTH(MAX_WIDTH)
  ) i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_command       (in_command),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_edge_value   (out_edge_value),
    .out_row          (out_row),
    .out_col          (out_col),
    .out_last_of_frame(out_last_of_frame),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .compared         (compared)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    out_ready <= (gaps_on && $urandom_range(0, 99) < 9) ? 1'b0 : 1'b1;
  end

  function automatic int unsigned clamp_size(int unsigned v, int unsigned top_v);
    if (v == 0) return 1;
    return (v > top_v) ? top_v : v;
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_width();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 4095;
      2: return MAX_WIDTH;
      3: return $urandom_range(17, MAX_WIDTH - 1);
      4: return $urandom_range(1, 3);
      default: return $urandom_range(1, 16);
    endcase
  endfunction

  function automatic int unsigned pick_height();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 8191;
      2: return MAX_HEIGHT;
      3: return $urandom_range(11, MAX_HEIGHT - 1);
      4: return $urandom_range(1, 3);
      default: return $urandom_range(1, 10);
    endcase
  endfunction

  // valid stays high from one word to the next unless a gap is drawn
  task automatic send_word(input cmd_t cmd, input logic [PIX_W-1:0] pix);
    while (gaps_on && $urandom_range(0, 99) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_pixel   <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_words++;
    // inputs taken but not yet answered, so the tail can be flushed exactly
    if (cmd == CMD_FLUSH) begin
      n_flush++;
      if (held != 0) held--;
    end else begin
      held++;
      if (held > HALF * cur_w + HALF) held--;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    // a word that gives no result may still be in the pipe
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [APB_DW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * idx);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    if (idx == REG_FRAME_WIDTH) cur_w = clamp_size(val[FW_W-1:0], MAX_WIDTH);
    else cur_h = clamp_size(val[FH_W-1:0], MAX_HEIGHT);
    n_cfg++;
  endtask

  task automatic set_frame(input int unsigned fw, input int unsigned fh);
    drain();
    cfg_write(REG_FRAME_WIDTH, fw);
    cfg_write(REG_FRAME_HEIGHT, fh);
  endtask

  task automatic flush_all();
    while (held != 0) send_word(CMD_FLUSH, rand_pixel());
  endtask

  initial begin
    int unsigned k, n, n_rand, frame_px, phase;
    n_rand = 0;
    phase  = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset geometry: row 0 is all border, the fourth flush finds nothing pending
    send_word(CMD_PIXEL, 8'd0);
    send_word(CMD_PIXEL, 8'd255);
    send_word(CMD_PIXEL, 8'd128);
    repeat (4) send_word(CMD_FLUSH, 8'hA5);

    // change mid-row to 1x1: first answer sits outside the frame, then all wrap
    set_frame(1, 1);
    repeat (2) send_word(CMD_PIXEL, rand_pixel());
    send_word(CMD_FLUSH, 8'h5A);
    flush_all();

    // single interior pixel at full contrast
    set_frame(3, 3);
    for (k = 0; k < 9; k++) send_word(CMD_PIXEL, (k == 4) ? 8'd255 : 8'd0);
    flush_all();

    // fill every column of all line slots so later partial frames read written data
    set_frame(4095, 3);
    gaps_on = 1'b1;
    repeat (WINDOW * MAX_WIDTH) send_word(CMD_PIXEL, rand_pixel());
    flush_all();

    while (n_rand < RANDOM_WORDS) begin
      phase++;
      gaps_on = (phase % 6 != 3);
      set_frame(pick_width(), pick_height());
      frame_px = cur_w * cur_h;
      if (frame_px <= 200) begin
        n = frame_px * $urandom_range(1, 2);
        if ($urandom_range(0, 1) != 0) n += $urandom_range(0, frame_px - 1);
      end else begin
        n = $urandom_range(20, 200);
      end
      repeat (n) begin
        if ($urandom_range(0, 99) < 4) send_word(CMD_FLUSH, rand_pixel());
        else send_word(CMD_PIXEL, rand_pixel());
      end
      n_rand += n;
      // sometimes the tail is left for the next setting to answer
      if ($urandom_range(0, 3) != 0) flush_all();
      if ($urandom_range(0, 4) == 0) send_word(CMD_FLUSH, rand_pixel());
    end

    drain();
    $display("sent %0d words (%0d flushes) over %0d register writes and %0d random phases",
             n_words, n_flush, n_cfg, phase);
    $display("compared %0d result words, %0d mismatches", compared, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results still expected", outstanding);
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ homogeneity_edge_operator.f @@
design/hedge_pkg.sv
design/hedge_ram.sv
design/homogeneity_edge_operator.sv
tb/sv/edge_map_checker.sv
tb/sv/tb_homogeneity_edge_operator.sv
